// ===== rtl/btcw_pkg.sv =====
`timescale 1ns / 1ps

package btcw_pkg;

    // Font store geometry
    localparam int GLYPH_ROWS  = 16;
    localparam int GLYPH_COUNT = 256;
    localparam int MAX_PLANES  = 4;

    // Input operation codes
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_FONT  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_SCROLL = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] REG_COLUMNS   = 3'd0;
    localparam logic [2:0] REG_LINES     = 3'd1;
    localparam logic [2:0] REG_PLANES    = 3'd2;
    localparam logic [2:0] REG_HEIGHT    = 3'd3;
    localparam logic [2:0] REG_ATTRIBUTE = 3'd4;

    // Control characters
    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_LF  = 8'h0a;
    localparam logic [7:0] CHAR_CR  = 8'h0d;

    typedef enum logic [2:0] {
        CMD_FONT,
        CMD_CLEAR,
        CMD_TAB,
        CMD_NEWLINE,
        CMD_GLYPH
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  char_code;
        logic [11:0] font_index;
        logic [7:0]  font_data;
    } cmd_t;

    typedef struct packed {
        logic [6:0] num_columns;
        logic [4:0] num_lines;
        logic [2:0] num_planes;
        logic [4:0] glyph_height;
        logic [7:0] attribute;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [14:0] address;
        logic [7:0]  write_data;
        logic [3:0]  fill_planes;
        logic [6:0]  cursor_column;
        logic [4:0]  cursor_line;
        logic        last;
    } res_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_EMIT,
        B_SETUP1,
        B_SETUP2,
        B_RENDER
    } back_state_t;

endpackage

// ===== rtl/bitplane_text_console_writer_top.sv =====
`timescale 1ns / 1ps

// Bitplane text console writer. Each input beat is an operation: put a
// character, load one font byte (row * 256 + code) or clear the screen.
// Every output beat is one result: a video memory byte write, a scroll
// request, a clear request or a configuration error, all tagged with the
// cursor after that item; tlast marks the last result of an item. Font
// loads and undefined operations give no result. A front stage sorts
// beats into a two-entry command queue, so input keeps flowing while the
// back end draws, until both entries are full. A printable glyph goes
// through B_SETUP1 and B_SETUP2, then one byte write per glyph row and
// plane (glyph rows times planes, at most 32), plus a scroll request when
// it wraps off the last line, paced by the single font store read port
// and the output register. Configuration is written through cfg_we/
// cfg_index/cfg_data; the user must do so only while idle, as the block itself does not enforce it.

module bitplane_text_console_writer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // char_code, font_index, font_data, pad
    input  logic [1:0]  s_axis_tuser,   // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // address, write_data, fill_planes,
                                        // cursor_column, cursor_line, pad
    output logic [1:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast,   // last
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import btcw_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;
    res_t res;

    // register file, reset to an 80x25 single-plane screen
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_COLUMNS:   cfg_next.num_columns  = cfg_data[6:0];
                REG_LINES:     cfg_next.num_lines    = cfg_data[4:0];
                REG_PLANES:    cfg_next.num_planes   = cfg_data[2:0];
                REG_HEIGHT:    cfg_next.glyph_height = cfg_data[4:0];
                REG_ATTRIBUTE: cfg_next.attribute    = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_columns  <= 7'd80;
            cfg_reg.num_lines    <= 5'd25;
            cfg_reg.num_planes   <= 3'd1;
            cfg_reg.glyph_height <= 5'd16;
            cfg_reg.attribute    <= 8'd15;
        end
        else
            cfg_reg <= cfg_next;
    end

    btcw_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_operation  (s_axis_tuser),
        .in_char_code  (s_axis_tdata[7:0]),
        .in_font_index (s_axis_tdata[19:8]),
        .in_font_data  (s_axis_tdata[27:20]),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop)
    );

    btcw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    // result beat packing, lowest field first
    assign m_axis_tdata = {1'b0, res.cursor_line, res.cursor_column, res.fill_planes,
                           res.write_data, res.address};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;

endmodule

// ===== rtl/btcw_front.sv =====
`timescale 1ns / 1ps

module btcw_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [1:0]      in_operation,
    input  logic [7:0]      in_char_code,
    input  logic [11:0]     in_font_index,
    input  logic [7:0]      in_font_data,
    output logic            cmd_valid,
    output btcw_pkg::cmd_t  cmd,
    input  logic            cmd_pop
);
    import btcw_pkg::*;

    localparam int DEPTH = 2;

    cmd_t       q_reg [DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       keep;
    logic       push;
    cmd_t       cls;

    // classify the incoming beat
    always_comb
    begin
        keep           = 1'b1;
        cls.char_code  = in_char_code;
        cls.font_index = in_font_index;
        cls.font_data  = in_font_data;
        cls.kind       = CMD_GLYPH;
        case (in_operation)
            OP_FONT:  cls.kind = CMD_FONT;
            OP_CLEAR: cls.kind = CMD_CLEAR;
            OP_PUT:
            begin
                if (in_char_code == CHAR_TAB)
                    cls.kind = CMD_TAB;
                else if (in_char_code == CHAR_LF || in_char_code == CHAR_CR)
                    cls.kind = CMD_NEWLINE;
                else
                    cls.kind = CMD_GLYPH;
            end
            default:  keep = 1'b0;   // undefined operation: dropped
        endcase
    end

    assign in_ready  = (count_reg != 2'(DEPTH));
    assign push      = in_valid && in_ready && keep;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(cmd_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= cls;
    end

endmodule

// ===== rtl/btcw_back.sv =====
`timescale 1ns / 1ps

module btcw_back (
    input  logic            clk,
    input  logic            rst_n,
    input  btcw_pkg::cfg_t  cfg,
    input  logic            cmd_valid,
    input  btcw_pkg::cmd_t  cmd,
    output logic            cmd_pop,
    output logic            out_valid,
    input  logic            out_ready,
    output btcw_pkg::res_t  out_res
);
    import btcw_pkg::*;

    back_state_t state_reg, state_next;
    logic [6:0]  cx_reg, cx_next;          // cursor after the latest item
    logic [4:0]  cy_reg, cy_next;
    logic [6:0]  x_reg, x_next;            // glyph position being drawn
    logic [4:0]  y_reg, y_next;
    logic [7:0]  char_reg, char_next;
    logic        scroll_reg, scroll_next;
    logic [1:0]  kind_reg, kind_next;
    logic [9:0]  yh_reg, yh_next;
    logic [9:0]  stride_reg, stride_next;
    logic [9:0]  xoff_reg, xoff_next;
    logic [14:0] base_reg, base_next;
    logic [3:0]  row_reg, row_next;
    logic [1:0]  j_reg, j_next;

    logic        out_valid_reg;
    res_t        out_reg;
    res_t        out_next;
    logic        out_load;
    logic        slot_free;

    logic [7:0]  font_mem [GLYPH_ROWS * GLYPH_COUNT];
    logic [7:0]  glyph_q;
    logic        font_we;
    logic        font_re;
    logic [11:0] font_raddr;

    logic [2:0]  used_planes;
    logic [4:0]  used_rows;
    logic [3:0]  fill_bits;
    logic        too_many;
    logic [7:0]  tab_x;
    logic [5:0]  ny;
    logic        nl_scroll;
    logic [4:0]  nl_y;
    logic        wrap;
    logic        last_plane;
    logic        last_row;
    logic        fg;
    logic        bg;
    logic [19:0] base_prod;

    assign used_planes = (cfg.num_planes > 3'(MAX_PLANES)) ? 3'(MAX_PLANES) : cfg.num_planes;
    assign used_rows   = (cfg.glyph_height > 5'(GLYPH_ROWS)) ? 5'(GLYPH_ROWS)
                                                             : cfg.glyph_height;
    assign fill_bits   = cfg.attribute[7:4] & 4'((5'd1 << used_planes) - 5'd1);
    assign too_many    = ({5'd0, cfg.num_planes} * {3'd0, cfg.glyph_height}) > 8'd32;

    // line feed: column home, next line or hold on the last one and scroll
    assign ny        = {1'b0, cy_reg} + 6'd1;
    assign nl_scroll = (ny >= {1'b0, cfg.num_lines});
    assign nl_y      = nl_scroll ? ((cfg.num_lines == 5'd0) ? 5'd0 : cfg.num_lines - 5'd1)
                                 : ny[4:0];
    assign tab_x     = {1'b0, cx_reg} + 8'd8 - {5'd0, cx_reg[2:0]};

    assign last_plane = ({1'b0, j_reg} == used_planes - 3'd1);
    assign last_row   = ({1'b0, row_reg} == used_rows - 5'd1);
    assign fg         = cfg.attribute[{1'b0, j_reg}];
    assign bg         = cfg.attribute[{1'b1, j_reg}];
    assign base_prod  = {10'd0, yh_reg} * {10'd0, stride_reg};

    assign slot_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next  = state_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        char_next   = char_reg;
        scroll_next = scroll_reg;
        kind_next   = kind_reg;
        yh_next     = yh_reg;
        stride_next = stride_reg;
        xoff_next   = xoff_reg;
        base_next   = base_reg;
        row_next    = row_reg;
        j_next      = j_reg;
        cmd_pop     = 1'b0;
        font_we     = 1'b0;
        font_re     = 1'b0;
        font_raddr  = {row_reg, char_reg};
        out_load    = 1'b0;
        wrap        = 1'b0;

        out_next.kind          = KIND_WRITE;
        out_next.address       = base_reg + {12'd0, j_reg, 1'b0};
        out_next.write_data    = ({8{fg}} & glyph_q) | ({8{bg}} & ~glyph_q);
        out_next.fill_planes   = 4'd0;
        out_next.cursor_column = cx_reg;
        out_next.cursor_line   = cy_reg;
        out_next.last          = 1'b0;

        case (state_reg)
            B_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.kind)
                        CMD_FONT:
                        begin
                            font_we = 1'b1;
                        end
                        CMD_CLEAR:
                        begin
                            cx_next    = 7'd0;
                            cy_next    = 5'd0;
                            kind_next  = KIND_CLEAR;
                            state_next = B_EMIT;
                        end
                        CMD_TAB, CMD_NEWLINE:
                        begin
                            wrap = (cmd.kind == CMD_NEWLINE) ||
                                   (tab_x >= {1'b0, cfg.num_columns});
                            if (!wrap)
                                cx_next = tab_x[6:0];
                            else
                            begin
                                cx_next = 7'd0;
                                cy_next = nl_y;
                                if (nl_scroll)
                                begin
                                    kind_next  = KIND_SCROLL;
                                    state_next = B_EMIT;
                                end
                            end
                        end
                        CMD_GLYPH:
                        begin
                            if (too_many)
                            begin
                                kind_next  = KIND_ERROR;
                                state_next = B_EMIT;
                            end
                            else
                            begin
                                x_next      = cx_reg;
                                y_next      = cy_reg;
                                char_next   = cmd.char_code;
                                wrap        = ({1'b0, cx_reg} + 8'd1) >=
                                              {1'b0, cfg.num_columns};
                                scroll_next = wrap && nl_scroll;
                                if (!wrap)
                                    cx_next = cx_reg + 7'd1;
                                else
                                begin
                                    cx_next = 7'd0;
                                    cy_next = nl_y;
                                end
                                state_next = B_SETUP1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            B_EMIT:
            begin
                out_next.kind       = kind_reg;
                out_next.address    = 15'd0;
                out_next.write_data = 8'd0;
                out_next.fill_planes = (kind_reg == KIND_SCROLL || kind_reg == KIND_CLEAR)
                                       ? fill_bits : 4'd0;
                out_next.last       = 1'b1;
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    state_next = B_IDLE;
                end
            end
            B_SETUP1:
            begin
                yh_next     = {5'd0, y_reg} * {5'd0, cfg.glyph_height};
                stride_next = {3'd0, cfg.num_columns} * {7'd0, used_planes};
                xoff_next   = {3'd0, x_reg[6:1], 1'b0} * {7'd0, used_planes}
                              + {9'd0, x_reg[0]};
                state_next  = B_SETUP2;
            end
            B_SETUP2:
            begin
                base_next  = base_prod[14:0] + {5'd0, xoff_reg};
                row_next   = 4'd0;
                j_next     = 2'd0;
                font_re    = 1'b1;
                font_raddr = {4'd0, char_reg};
                if (used_rows == 5'd0 || used_planes == 3'd0)
                begin
                    if (scroll_reg)
                    begin
                        kind_next  = KIND_SCROLL;
                        state_next = B_EMIT;
                    end
                    else
                        state_next = B_IDLE;
                end
                else
                    state_next = B_RENDER;
            end
            B_RENDER:
            begin
                out_next.last = last_row && last_plane && !scroll_reg;
                if (slot_free)
                begin
                    out_load = 1'b1;
                    if (last_plane)
                    begin
                        // next glyph row: fetch it while this beat goes out
                        j_next     = 2'd0;
                        row_next   = row_reg + 4'd1;
                        base_next  = base_reg + {5'd0, stride_reg};
                        font_re    = 1'b1;
                        font_raddr = {row_reg + 4'd1, char_reg};
                        if (last_row)
                        begin
                            if (scroll_reg)
                            begin
                                kind_next  = KIND_SCROLL;
                                state_next = B_EMIT;
                            end
                            else
                                state_next = B_IDLE;
                        end
                    end
                    else
                        j_next = j_reg + 2'd1;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            cx_reg        <= 7'd0;
            cy_reg        <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        y_reg      <= y_next;
        char_reg   <= char_next;
        scroll_reg <= scroll_next;
        kind_reg   <= kind_next;
        yh_reg     <= yh_next;
        stride_reg <= stride_next;
        xoff_reg   <= xoff_next;
        base_reg   <= base_next;
        row_reg    <= row_next;
        j_reg      <= j_next;
        if (out_load)
            out_reg <= out_next;
    end

    // font store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (font_we)
            font_mem[cmd.font_index] <= cmd.font_data;
        if (font_re)
            glyph_q <= font_mem[font_raddr];
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

endmodule
